FILE: sv/lobm_pkg.sv
package lobm_pkg;

	localparam int LEVELS_PER_SIDE_DEF  = 8;
	localparam int ORDERS_PER_LEVEL_DEF = 4;

	localparam int PRICE_W = 20;
	localparam int QTY_W   = 16;
	localparam int ID_W    = 32;
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_MARKET = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GTC    = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OPP_INIT,
		ST_OPP_SCAN,
		ST_OPP_EVAL,
		ST_MSLOT_SCAN,
		ST_MSLOT_EVAL,
		ST_FILL,
		ST_REST_CHK,
		ST_OWN_SCAN,
		ST_OWN_EVAL,
		ST_RSLOT_SCAN,
		ST_RSLOT_EVAL,
		ST_REF_BID,
		ST_REF_ASK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SCAN_OPP,
		SCAN_OWN,
		SCAN_BID,
		SCAN_ASK
	} scan_sel_t;

	typedef struct packed {
		logic      load;
		logic      lscan_init;
		scan_sel_t lscan_sel;
		logic      lscan_step;
		logic      take_best;
		logic      take_own;
		logic      sscan_init;
		logic      sscan_step;
		logic      clear_level;
		logic      fill;
		logic      set_full;
		logic      rest_write;
		logic      save_bid;
		logic      emit_sum;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic best_found;
		logic limit_bad;
		logic slot_done;
		logic min_found;
		logic rem_zero;
		logic rest_wanted;
		logic own_avail;
		logic free_slot_found;
	} sts_t;

endpackage

FILE: sv/limit_order_book_matcher.sv
// channel   | direction | handshake                | payload
// order     | in        | start high, busy low     | side order_kind limit_price quantity order_id
// result    | out       | result_strobe, one cycle | is_fill maker_id fill_price fill_quantity
//           |           |                          | remaining rested status reference_price last
//
// one order at a time: busy stays high from the accepting edge until the summary goes out
// the serial scans over levels and slots set how long each order takes
// reset is asynchronous, active low: book emptied (level valid and slot written flags cleared)
// results cannot be stalled: each is on the ports for exactly one cycle
module limit_order_book_matcher
	import lobm_pkg::*;
	#(
		parameter int LEVELS_PER_SIDE  = LEVELS_PER_SIDE_DEF,
		parameter int ORDERS_PER_LEVEL = ORDERS_PER_LEVEL_DEF
	)
	(
		input  logic               clk,
		input  logic               arst_n,
		input  logic               start,
		output logic               busy,
		input  logic               side,
		input  logic [KIND_W-1:0]  order_kind,
		input  logic [PRICE_W-1:0] limit_price,
		input  logic [QTY_W-1:0]   quantity,
		input  logic [ID_W-1:0]    order_id,
		output logic               result_strobe,
		output logic               is_fill,
		output logic [ID_W-1:0]    maker_id,
		output logic [PRICE_W-1:0] fill_price,
		output logic [QTY_W-1:0]   fill_quantity,
		output logic [QTY_W-1:0]   remaining,
		output logic               rested,
		output logic               status,
		output logic [PRICE_W-1:0] reference_price,
		output logic               last
	);

	// commands from the sequencer, status back from the book datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: walks opposite levels, slots, resting and the reference scan
	lobm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: level registers, slot memories and the result register
	lobm_dp #(
		.LEVELS_PER_SIDE  (LEVELS_PER_SIDE),
		.ORDERS_PER_LEVEL (ORDERS_PER_LEVEL)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.side            (side),
		.order_kind      (order_kind),
		.limit_price     (limit_price),
		.quantity        (quantity),
		.order_id        (order_id),
		.result_strobe   (result_strobe),
		.is_fill         (is_fill),
		.maker_id        (maker_id),
		.fill_price      (fill_price),
		.fill_quantity   (fill_quantity),
		.remaining       (remaining),
		.rested          (rested),
		.status          (status),
		.reference_price (reference_price),
		.last            (last)
	);

endmodule

FILE: sv/lobm_ram.sv
module lobm_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/lobm_ctrl.sv
module lobm_ctrl
	import lobm_pkg::*;
	(
		input  logic clk,
		input  logic arst_n,
		input  logic start,
		input  sts_t sts,
		output cmd_t cmd,
		output logic busy
	);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (start) state_d = ST_OPP_INIT;
			ST_OPP_INIT:   state_d = sts.rem_zero ? ST_REST_CHK : ST_OPP_SCAN;
			ST_OPP_SCAN:   if (sts.scan_last) state_d = ST_OPP_EVAL;
			ST_OPP_EVAL: begin
				if (!sts.best_found || sts.limit_bad) state_d = ST_REST_CHK;
				else state_d = ST_MSLOT_SCAN;
			end
			ST_MSLOT_SCAN: if (sts.slot_done) state_d = ST_MSLOT_EVAL;
			ST_MSLOT_EVAL: begin
				if (!sts.min_found) state_d = ST_OPP_INIT;
				else if (sts.rem_zero) state_d = ST_REST_CHK;
				else state_d = ST_FILL;
			end
			ST_FILL:       state_d = ST_MSLOT_SCAN;
			ST_REST_CHK:   state_d = sts.rest_wanted ? ST_OWN_SCAN : ST_REF_BID;
			ST_OWN_SCAN:   if (sts.scan_last) state_d = ST_OWN_EVAL;
			ST_OWN_EVAL:   state_d = sts.own_avail ? ST_RSLOT_SCAN : ST_REF_BID;
			ST_RSLOT_SCAN: if (sts.slot_done) state_d = ST_RSLOT_EVAL;
			ST_RSLOT_EVAL: state_d = ST_REF_BID;
			ST_REF_BID:    if (sts.scan_last) state_d = ST_REF_ASK;
			ST_REF_ASK:    if (sts.scan_last) state_d = ST_DONE;
			ST_DONE:       state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.lscan_sel = SCAN_OPP;
		case (state_q)
			ST_IDLE:     cmd.load = start;
			ST_OPP_INIT: begin
				cmd.lscan_init = !sts.rem_zero;
				cmd.lscan_sel  = SCAN_OPP;
			end
			ST_OPP_SCAN: cmd.lscan_step = 1'b1;
			ST_OPP_EVAL: begin
				if (sts.best_found && !sts.limit_bad) begin
					cmd.take_best  = 1'b1;
					cmd.sscan_init = 1'b1;
				end
			end
			ST_MSLOT_SCAN: cmd.sscan_step = 1'b1;
			ST_MSLOT_EVAL: cmd.clear_level = !sts.min_found;
			ST_FILL: begin
				cmd.fill       = 1'b1;
				cmd.sscan_init = 1'b1;
			end
			ST_REST_CHK: begin
				cmd.lscan_init = 1'b1;
				cmd.lscan_sel  = sts.rest_wanted ? SCAN_OWN : SCAN_BID;
			end
			ST_OWN_SCAN: cmd.lscan_step = 1'b1;
			ST_OWN_EVAL: begin
				cmd.take_own   = sts.own_avail;
				cmd.sscan_init = sts.own_avail;
				cmd.set_full   = !sts.own_avail;
				cmd.lscan_init = !sts.own_avail;
				cmd.lscan_sel  = SCAN_BID;
			end
			ST_RSLOT_SCAN: cmd.sscan_step = 1'b1;
			ST_RSLOT_EVAL: begin
				cmd.rest_write = sts.free_slot_found;
				cmd.set_full   = !sts.free_slot_found;
				cmd.lscan_init = 1'b1;
				cmd.lscan_sel  = SCAN_BID;
			end
			ST_REF_BID: begin
				cmd.lscan_step = 1'b1;
				if (sts.scan_last) begin
					cmd.save_bid   = 1'b1;
					cmd.lscan_init = 1'b1;
					cmd.lscan_sel  = SCAN_ASK;
				end
			end
			ST_REF_ASK: cmd.lscan_step = 1'b1;
			ST_DONE:    cmd.emit_sum = 1'b1;
			default:    cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: sv/lobm_dp.sv
module lobm_dp
	import lobm_pkg::*;
	#(
		parameter int LEVELS_PER_SIDE  = LEVELS_PER_SIDE_DEF,
		parameter int ORDERS_PER_LEVEL = ORDERS_PER_LEVEL_DEF
	)
	(
		input  logic                clk,
		input  logic                arst_n,
		input  cmd_t                cmd,
		output sts_t                sts,
		input  logic                side,
		input  logic [KIND_W-1:0]   order_kind,
		input  logic [PRICE_W-1:0]  limit_price,
		input  logic [QTY_W-1:0]    quantity,
		input  logic [ID_W-1:0]     order_id,
		output logic                result_strobe,
		output logic                is_fill,
		output logic [ID_W-1:0]     maker_id,
		output logic [PRICE_W-1:0]  fill_price,
		output logic [QTY_W-1:0]    fill_quantity,
		output logic [QTY_W-1:0]    remaining,
		output logic                rested,
		output logic                status,
		output logic [PRICE_W-1:0]  reference_price,
		output logic                last
	);

	localparam int NLEV  = 2 * LEVELS_PER_SIDE;
	localparam int NSLOT = NLEV * ORDERS_PER_LEVEL;
	localparam int LW    = $clog2(NLEV);
	localparam int SW    = $clog2(NSLOT);
	localparam int IW    = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
	localparam int JW    = $clog2(ORDERS_PER_LEVEL + 1);
	localparam int JOW   = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;

	// order registers
	logic               side_q;
	logic [KIND_W-1:0]  kind_q;
	logic [PRICE_W-1:0] limit_q;
	logic [QTY_W-1:0]   rem_q;
	logic [ID_W-1:0]    id_q;
	logic               rested_q, full_q;

	// book levels
	logic [PRICE_W-1:0] level_price_q [NLEV];
	logic [NLEV-1:0]    level_valid_q;
	logic [NSLOT-1:0]   slot_written_q;

	// level scan
	logic [IW-1:0]      i_q;
	logic               scan_side_q;
	logic [LW-1:0]      best_q;
	logic               best_found_q;
	logic [PRICE_W-1:0] best_price_q;
	logic [PRICE_W-1:0] bid_price_q;
	logic               bid_found_q;
	logic [LW-1:0]      match_lv_q, free_lv_q;
	logic               match_found_q, free_lv_found_q;

	// slot scan
	logic [LW-1:0]      tgt_q;
	logic [PRICE_W-1:0] cur_price_q;
	logic [JW-1:0]      j_q;
	logic               rd_s1, qv_s1;
	logic [JOW-1:0]     rj_s1;
	logic [SW-1:0]      sa_s1;
	logic [SW-1:0]      min_slot_q, free_slot_q;
	logic               min_found_q, free_slot_found_q;
	logic [ID_W-1:0]    min_id_q;
	logic [QTY_W-1:0]   min_qty_q;

	// output registers
	logic               out_valid_q, out_fill_q, out_rested_q, out_status_q, out_last_q;
	logic [ID_W-1:0]    out_maker_q;
	logic [PRICE_W-1:0] out_price_q, out_ref_q;
	logic [QTY_W-1:0]   out_fq_q, out_rem_q;

	logic [LW-1:0]      lv;
	logic               lv_valid;
	logic [PRICE_W-1:0] lv_price;
	logic               lv_better;
	logic               issue;
	logic [SW-1:0]      raddr, waddr;
	logic [ID_W-1:0]    rd_id;
	logic [QTY_W-1:0]   rd_qty, slot_q, fq;
	logic               ram_we, id_we;
	logic [QTY_W-1:0]   qty_wdata;
	logic [PRICE_W:0]   mid_sum;
	logic [PRICE_W-1:0] ref_price;
	logic               scan_side_d;

	assign lv       = LW'(scan_side_q) * LW'(LEVELS_PER_SIDE) + LW'(i_q);
	assign lv_valid = level_valid_q[lv];
	assign lv_price = level_price_q[lv];
	assign lv_better = !best_found_q ||
		(!scan_side_q && lv_price > best_price_q) ||
		( scan_side_q && lv_price < best_price_q);

	assign issue  = j_q < JW'(ORDERS_PER_LEVEL);
	assign raddr  = SW'(tgt_q) * SW'(ORDERS_PER_LEVEL) + SW'(j_q);
	assign slot_q = qv_s1 ? rd_qty : '0;
	assign fq     = (rem_q < min_qty_q) ? rem_q : min_qty_q;

	assign ram_we    = cmd.fill || cmd.rest_write;
	assign id_we     = cmd.rest_write;
	assign waddr     = cmd.fill ? min_slot_q : free_slot_q;
	assign qty_wdata = cmd.fill ? (min_qty_q - fq) : rem_q;

	assign mid_sum = {1'b0, bid_price_q} + {1'b0, best_price_q};
	always_comb begin
		if (bid_found_q && best_found_q) ref_price = mid_sum[PRICE_W:1];
		else if (bid_found_q) ref_price = bid_price_q;
		else if (best_found_q) ref_price = best_price_q;
		else ref_price = '0;
	end

	always_comb begin
		case (cmd.lscan_sel)
			SCAN_OPP: scan_side_d = !side_q;
			SCAN_OWN: scan_side_d = side_q;
			SCAN_BID: scan_side_d = 1'b0;
			SCAN_ASK: scan_side_d = 1'b1;
			default:  scan_side_d = 1'b0;
		endcase
	end

	lobm_ram #(.WIDTH(ID_W), .DEPTH(NSLOT)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (waddr),
		.wdata (id_q),
		.raddr (raddr),
		.rdata (rd_id)
	);

	lobm_ram #(.WIDTH(QTY_W), .DEPTH(NSLOT)) u_qty_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (qty_wdata),
		.raddr (raddr),
		.rdata (rd_qty)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_valid_q  <= '0;
			slot_written_q <= '0;
			out_valid_q    <= 1'b0;
			rd_s1          <= 1'b0;
		end else begin
			out_valid_q <= cmd.fill || cmd.emit_sum;
			if (cmd.clear_level) level_valid_q[tgt_q] <= 1'b0;
			if (cmd.rest_write) level_valid_q[tgt_q] <= 1'b1;
			if (ram_we) slot_written_q[waddr] <= 1'b1;
			if (cmd.sscan_init) rd_s1 <= 1'b0;
			else if (cmd.sscan_step) rd_s1 <= issue;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q   <= side;
			kind_q   <= order_kind;
			limit_q  <= limit_price;
			rem_q    <= quantity;
			id_q     <= order_id;
			rested_q <= 1'b0;
			full_q   <= 1'b0;
		end
		if (cmd.set_full) full_q <= 1'b1;
		if (cmd.rest_write) begin
			rested_q             <= 1'b1;
			level_price_q[tgt_q] <= limit_q;
		end

		// the last bid level is folded in as the best is saved
		if (cmd.save_bid) begin
			if (lv_valid && lv_better) begin
				bid_price_q <= lv_price;
				bid_found_q <= 1'b1;
			end else begin
				bid_price_q <= best_price_q;
				bid_found_q <= best_found_q;
			end
		end
		if (cmd.lscan_init) begin
			i_q             <= '0;
			scan_side_q     <= scan_side_d;
			best_found_q    <= 1'b0;
			match_found_q   <= 1'b0;
			free_lv_found_q <= 1'b0;
		end else if (cmd.lscan_step) begin
			i_q <= i_q + IW'(1);
			if (lv_valid && lv_better) begin
				best_q       <= lv;
				best_price_q <= lv_price;
				best_found_q <= 1'b1;
			end
			if (lv_valid && lv_price == limit_q && !match_found_q) begin
				match_lv_q    <= lv;
				match_found_q <= 1'b1;
			end
			if (!lv_valid && !free_lv_found_q) begin
				free_lv_q       <= lv;
				free_lv_found_q <= 1'b1;
			end
		end

		if (cmd.take_best) begin
			tgt_q       <= best_q;
			cur_price_q <= best_price_q;
		end
		if (cmd.take_own) tgt_q <= match_found_q ? match_lv_q : free_lv_q;

		if (cmd.sscan_init) begin
			j_q               <= '0;
			min_found_q       <= 1'b0;
			free_slot_found_q <= 1'b0;
		end else if (cmd.sscan_step) begin
			if (issue) j_q <= j_q + JW'(1);
			rj_s1 <= JOW'(j_q);
			sa_s1 <= raddr;
			qv_s1 <= slot_written_q[raddr];
			if (rd_s1) begin
				// strict compare keeps the lower slot on equal ids
				if (slot_q != '0 && (!min_found_q || rd_id < min_id_q)) begin
					min_found_q <= 1'b1;
					min_slot_q  <= sa_s1;
					min_id_q    <= rd_id;
					min_qty_q   <= slot_q;
				end
				if (slot_q == '0 && !free_slot_found_q) begin
					free_slot_found_q <= 1'b1;
					free_slot_q       <= sa_s1;
				end
			end
		end

		if (cmd.fill) begin
			rem_q        <= rem_q - fq;
			out_fill_q   <= 1'b1;
			out_maker_q  <= min_id_q;
			out_price_q  <= cur_price_q;
			out_fq_q     <= fq;
			out_rem_q    <= '0;
			out_rested_q <= 1'b0;
			out_status_q <= 1'b0;
			out_ref_q    <= '0;
			out_last_q   <= 1'b0;
		end else if (cmd.emit_sum) begin
			out_fill_q   <= 1'b0;
			out_maker_q  <= '0;
			out_price_q  <= '0;
			out_fq_q     <= '0;
			out_rem_q    <= rem_q;
			out_rested_q <= rested_q;
			out_status_q <= full_q;
			out_ref_q    <= ref_price;
			out_last_q   <= 1'b1;
		end
	end

	assign sts.scan_last       = (i_q == IW'(LEVELS_PER_SIDE - 1));
	assign sts.best_found      = best_found_q;
	assign sts.limit_bad       = (kind_q != KIND_MARKET) &&
		((!side_q && best_price_q > limit_q) || (side_q && best_price_q < limit_q));
	assign sts.slot_done       = rd_s1 && (rj_s1 == JOW'(ORDERS_PER_LEVEL - 1));
	assign sts.min_found       = min_found_q;
	assign sts.rem_zero        = (rem_q == '0);
	assign sts.rest_wanted     = (kind_q == KIND_GTC) && (rem_q != '0);
	assign sts.own_avail       = match_found_q || free_lv_found_q;
	assign sts.free_slot_found = free_slot_found_q;

	assign result_strobe   = out_valid_q;
	assign is_fill         = out_fill_q;
	assign maker_id        = out_maker_q;
	assign fill_price      = out_price_q;
	assign fill_quantity   = out_fq_q;
	assign remaining       = out_rem_q;
	assign rested          = out_rested_q;
	assign status          = out_status_q;
	assign reference_price = out_ref_q;
	assign last            = out_last_q;

	a_fill_has_maker: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> min_found_q && rem_q != '0)
		else $error("fill without a resting order or remainder");

	a_rest_only_gtc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest_write |-> free_slot_found_q && kind_q == KIND_GTC)
		else $error("rest write without free slot or not good till cancel");

	a_fill_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |=> result_strobe && is_fill && !last)
		else $error("fill not presented");

endmodule

FILE: test/tb.sv
module tb;
	import lobm_pkg::*;

	localparam int LVL = LEVELS_PER_SIDE_DEF;
	localparam int OPL = ORDERS_PER_LEVEL_DEF;
	localparam int NLV = 2 * LVL;
	localparam int NSL = NLV * OPL;
	localparam int N_RANDOM = 400;
	localparam longint CYCLE_LIMIT = 2000000;

	localparam logic [KIND_W-1:0] KIND_FAK    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic               is_fill;
		logic [ID_W-1:0]    maker_id;
		logic [PRICE_W-1:0] fill_price;
		logic [QTY_W-1:0]   fill_quantity;
		logic [QTY_W-1:0]   remaining;
		logic               rested;
		logic               status;
		logic [PRICE_W-1:0] reference_price;
		logic               last;
	} book_rec_t;

	// order book shadow: matches each order and queues the records it should cause
	class book_scoreboard;
		logic [PRICE_W-1:0] lv_price [NLV];
		logic               lv_valid [NLV];
		logic [ID_W-1:0]    sl_id [NSL];
		logic [QTY_W-1:0]   sl_qty [NSL];
		logic [PRICE_W-1:0] ref_px;
		book_rec_t          pending_records [$];
		int                 errors;
		int                 fills_seen;
		int                 rests_seen;
		int                 full_seen;

		function new();
			for (int i = 0; i < NLV; i++) begin
				lv_valid[i] = 1'b0;
				lv_price[i] = '0;
			end
			for (int i = 0; i < NSL; i++) begin
				sl_qty[i] = '0;
				sl_id[i] = '0;
			end
			ref_px = '0;
			errors = 0;
			fills_seen = 0;
			rests_seen = 0;
			full_seen = 0;
		endfunction

		function int best_of(int bs);
			int b;
			b = -1;
			for (int i = 0; i < LVL; i++) begin
				int l;
				l = bs * LVL + i;
				if (lv_valid[l] && (b < 0 || (bs == 0 && lv_price[l] > lv_price[b]) ||
						(bs == 1 && lv_price[l] < lv_price[b])))
					b = l;
			end
			return b;
		endfunction

		function void note_order(logic sd, logic [KIND_W-1:0] kd, logic [PRICE_W-1:0] lim,
				logic [QTY_W-1:0] qty, logic [ID_W-1:0] oid);
			logic [QTY_W-1:0] rem;
			logic rst, sts;
			book_rec_t r;
			int l, base, s, b, a, fl;
			logic [QTY_W-1:0] q;
			logic empty;
			logic [PRICE_W:0] sum;
			rem = qty;
			rst = 0;
			sts = 0;
			// walk the opposite side best level first
			while (rem != 0) begin
				l = best_of(sd ? 0 : 1);
				if (l < 0)
					break;
				if (kd != KIND_MARKET && ((!sd && lv_price[l] > lim) || (sd && lv_price[l] < lim)))
					break;
				base = l * OPL;
				while (rem != 0) begin
					s = -1;
					for (int j = 0; j < OPL; j++)
						if (sl_qty[base+j] != 0 && (s < 0 || sl_id[base+j] < sl_id[s]))
							s = base + j;
					if (s < 0)
						break;
					q = (rem < sl_qty[s]) ? rem : sl_qty[s];
					rem -= q;
					sl_qty[s] -= q;
					r = '{1'b1, sl_id[s], lv_price[l], q, '0, 1'b0, 1'b0, '0, 1'b0};
					pending_records.push_back(r);
				end
				empty = 1;
				for (int j = 0; j < OPL; j++)
					if (sl_qty[base+j] != 0)
						empty = 0;
				if (empty)
					lv_valid[l] = 0;
			end
			// good-till-cancel remainder rests on its own side
			if (kd == KIND_GTC && rem != 0) begin
				l = -1;
				fl = -1;
				for (int i = 0; i < LVL; i++) begin
					int t;
					t = sd * LVL + i;
					if (lv_valid[t]) begin
						if (lv_price[t] == lim && l < 0)
							l = t;
					end else if (fl < 0) begin
						fl = t;
					end
				end
				if (l < 0)
					l = fl;
				if (l < 0) begin
					sts = 1;
				end else begin
					base = l * OPL;
					s = -1;
					for (int j = 0; j < OPL; j++)
						if (s < 0 && sl_qty[base+j] == 0)
							s = base + j;
					if (s < 0) begin
						sts = 1;
					end else begin
						lv_valid[l] = 1;
						lv_price[l] = lim;
						sl_id[s] = oid;
						sl_qty[s] = rem;
						rst = 1;
					end
				end
			end
			b = best_of(0);
			a = best_of(1);
			if (b >= 0 && a >= 0) begin
				sum = lv_price[b] + lv_price[a];
				ref_px = sum[PRICE_W:1];
			end else if (b >= 0) begin
				ref_px = lv_price[b];
			end else if (a >= 0) begin
				ref_px = lv_price[a];
			end else begin
				ref_px = '0;
			end
			rests_seen += rst;
			full_seen += sts;
			r = '{1'b0, '0, '0, '0, rem, rst, sts, ref_px, 1'b1};
			pending_records.push_back(r);
		endfunction

		function void check_record(book_rec_t got);
			book_rec_t e;
			if (pending_records.size() == 0) begin
				report_mismatch("record with nothing pending");
				return;
			end
			e = pending_records.pop_front();
			if (got.is_fill)
				fills_seen++;
			if (got.is_fill !== e.is_fill) report_mismatch("is_fill");
			if (got.maker_id !== e.maker_id) report_mismatch("maker_id");
			if (got.fill_price !== e.fill_price) report_mismatch("fill_price");
			if (got.fill_quantity !== e.fill_quantity) report_mismatch("fill_quantity");
			if (got.remaining !== e.remaining) report_mismatch("remaining");
			if (got.rested !== e.rested) report_mismatch("rested");
			if (got.status !== e.status) report_mismatch("status");
			if (got.reference_price !== e.reference_price) report_mismatch("reference_price");
			if (got.last !== e.last) report_mismatch("last");
		endfunction

		function void report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("tb: mismatch on %s at %0t", what, $realtime);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               side;
	logic [KIND_W-1:0]  order_kind;
	logic [PRICE_W-1:0] limit_price;
	logic [QTY_W-1:0]   quantity;
	logic [ID_W-1:0]    order_id;
	logic               result_strobe;
	logic               is_fill;
	logic [ID_W-1:0]    maker_id;
	logic [PRICE_W-1:0] fill_price;
	logic [QTY_W-1:0]   fill_quantity;
	logic [QTY_W-1:0]   remaining;
	logic               rested;
	logic               status;
	logic [PRICE_W-1:0] reference_price;
	logic               last;

	book_scoreboard book;
	longint         cycle_count;
	int             orders_sent;

	limit_order_book_matcher dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.side(side), .order_kind(order_kind), .limit_price(limit_price),
		.quantity(quantity), .order_id(order_id),
		.result_strobe(result_strobe), .is_fill(is_fill), .maker_id(maker_id),
		.fill_price(fill_price), .fill_quantity(fill_quantity),
		.remaining(remaining), .rested(rested), .status(status),
		.reference_price(reference_price), .last(last)
	);

	// clock, period of two units
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// results are sampled at the rising edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1)
			book.check_record('{is_fill, maker_id, fill_price, fill_quantity, remaining,
				rested, status, reference_price, last});
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// send one order transaction: hold start until the edge where busy is low;
	// start stays high after acceptance, busy keeps the next edges from taking it
	task automatic send_order(logic sd, logic [KIND_W-1:0] kd, logic [PRICE_W-1:0] lim,
			logic [QTY_W-1:0] qty, logic [ID_W-1:0] oid, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		side <= sd;
		order_kind <= kd;
		limit_price <= lim;
		quantity <= qty;
		order_id <= oid;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		book.note_order(sd, kd, lim, qty, oid);
		orders_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (book.pending_records.size() != 0)
			@(posedge clk);
	endtask

	// random order: in mode 0 prices lie in a narrow band so that books cross and levels fill up; mode 1 takes any price
	task automatic send_random(int mode);
		logic [KIND_W-1:0] kd;
		logic [PRICE_W-1:0] lim;
		logic [QTY_W-1:0] qty;
		logic [ID_W-1:0] oid;
		int gap;
		int r;
		r = $urandom_range(0, 99);
		kd = (r < 60) ? KIND_GTC : (r < 78) ? KIND_FAK : (r < 95) ? KIND_MARKET : KIND_UNUSED;
		if (mode == 0)
			lim = PRICE_W'(1000 + $urandom_range(0, 24));
		else
			lim = PRICE_W'($urandom());
		r = $urandom_range(0, 9);
		qty = (r == 0) ? QTY_W'($urandom()) : (r == 1) ? 16'd0 : QTY_W'($urandom_range(1, 60));
		oid = ($urandom_range(0, 5) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom());
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		send_order(1'($urandom_range(0, 1)), kd, lim, qty, oid, gap);
	endtask

	initial begin
		book = new();
		cycle_count = 0;
		orders_sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		side = 1'b0;
		order_kind = KIND_MARKET;
		limit_price = '0;
		quantity = '0;
		order_id = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty book, extremes, every kind
		send_order(1'b0, KIND_MARKET, 20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF, 0);
		send_order(1'b0, KIND_GTC, 20'd0, 16'd0, 32'd1, 0);
		send_order(1'b1, KIND_GTC, 20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF, 0);
		send_order(1'b0, KIND_GTC, 20'd0, 16'd1, 32'd0, 1);
		// midpoint with both sides present, then a limit that stops short
		send_order(1'b0, KIND_FAK, 20'hFFFFE, 16'd5, 32'd2, 0);
		// equal ids at one level: lower slot first
		send_order(1'b1, KIND_GTC, 20'd500, 16'd3, 32'd7, 0);
		send_order(1'b1, KIND_GTC, 20'd500, 16'd4, 32'd7, 0);
		send_order(1'b1, KIND_GTC, 20'd500, 16'd2, 32'd3, 2);
		send_order(1'b0, KIND_FAK, 20'd500, 16'd6, 32'd9, 0);
		// unused kind behaves as fill and kill
		send_order(1'b0, KIND_UNUSED, 20'd500, 16'd10, 32'd10, 0);
		// market sweeps every level: the single resting bid fills in full, the market order only in part
		send_order(1'b1, KIND_MARKET, 20'd0, 16'h7FFF, 32'h80000000, 0);
		// fill one level then the side: full store
		for (int i = 0; i < 5; i++)
			send_order(1'b0, KIND_GTC, 20'd100, 16'd1, ID_W'(20 + i), 0);
		for (int i = 0; i < 8; i++)
			send_order(1'b0, KIND_GTC, PRICE_W'(200 + i), 16'd2, ID_W'(30 + i), 0);
		send_order(1'b1, KIND_MARKET, 20'd0, 16'hFFFF, 32'd99, 0);

		// pause until the book has answered everything
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				wait_drained();
			send_random((i % 10 == 9) ? 1 : 0);
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("tb: %0d orders, %0d fills, %0d rested, %0d dropped on full store",
			orders_sent, book.fills_seen, book.rests_seen, book.full_seen);
		if (book.errors == 0 && book.pending_records.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/lobm_pkg.sv
sv/lobm_ram.sv
sv/lobm_ctrl.sv
sv/lobm_dp.sv
sv/limit_order_book_matcher.sv
test/tb.sv
